// ===== hdl/sgm_pkg.sv =====
// Shared types and constants for the Sobel gradient magnitude block.
// Used by every module under hdl; depends on nothing else.
package sgm_pkg;

  localparam int REG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CMP_W      = 14;
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 21;
  localparam int ROOT_STEPS = 11;
  localparam int STEP_W     = 4;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam logic [REG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [REG_W-1:0] RESET_HEIGHT = 11'd480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // emission kinds, in output order
  localparam logic [1:0] EMIT_UP_LEFT   = 2'd0;
  localparam logic [1:0] EMIT_UP_RIGHT  = 2'd1;
  localparam logic [1:0] EMIT_LOW_LEFT  = 2'd2;
  localparam logic [1:0] EMIT_LOW_RIGHT = 2'd3;

  // win[slot][line]: slot 0 oldest column; line 0 two rows up, line 2 current
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    window_t                  win;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic [3:0]               mask;
    logic                     row_ge2;
    logic                     col_ge2;
  } entry_t;

  typedef enum logic {F_IDLE, F_UPDATE} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_GRAD, B_SQUARE, B_ROOT, B_OUT} back_state_t;

endpackage

// ===== hdl/sobel_gradient_magnitude.sv =====
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Holds the size registers; instantiates sgm_front, sgm_fifo and sgm_back; uses sgm_pkg.
//
// Pixels enter in raster order; each pixel passes a line-buffer read and then an
// update in the front end, and the update waits while the queue is full. Each result
// passes the gradient, square, root and output states in the back end, plus any wait
// on out_ready, with the root found by the 11-step iterative square root; each queued
// pixel also passes the idle state to leave the queue. A pixel yields 0 to 4 results.
// A 2-entry queue lets the front end run ahead of the back end. Writing either size
// register restarts the frame at row 0, column 0. Sizes below 2 act as 2, above the
// maximum as the maximum.
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgm_pkg::REG_W-1:0]          cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [sgm_pkg::PIX_W-1:0]          pixel,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sgm_pkg::COORD_W-1:0]        out_row,
  output logic [sgm_pkg::COORD_W-1:0]        out_col,
  output logic signed [sgm_pkg::GRAD_W-1:0]  grad_x,
  output logic signed [sgm_pkg::GRAD_W-1:0]  grad_y,
  output logic [sgm_pkg::GRAD_W-1:0]         grad_mag,
  output logic                               run_last,
  output logic                               frame_last
);
  import sgm_pkg::*;

  logic [REG_W-1:0]  image_width, image_height, eff_width, eff_height;
  logic              restart, push, full, pop, empty;
  entry_t            push_entry, pop_entry;
  logic [QCNT_W-1:0] q_count;

  function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v, input int maxv);
    logic [REG_W-1:0] r;
    r = v;
    if (v < REG_W'(2)) r = REG_W'(2);
    else if (32'(v) > 32'(maxv)) r = REG_W'(maxv);
    return r;
  endfunction

  assign eff_width  = clamp_size(image_width, MAX_WIDTH);
  assign eff_height = clamp_size(image_height, MAX_HEIGHT);
  assign restart    = cfg_write &&
                      (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  sgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .push        (push),
    .push_entry  (push_entry),
    .full        (full)
  );

  sgm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .pop_entry  (pop_entry),
    .count      (q_count)
  );

  sgm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .grad_mag   (grad_mag),
    .run_last   (run_last),
    .frame_last (frame_last)
  );

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame_last without run_last");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_quiet_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result word right after reset");

endmodule

// ===== hdl/sgm_front.sv =====
// Front end: takes pixels, reads and updates the two line buffers, keeps the window,
// and classifies which results each pixel releases. Depends on sgm_pkg.
module sgm_front #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic [sgm_pkg::REG_W-1:0]    eff_width,
  input  logic [sgm_pkg::REG_W-1:0]    eff_height,
  input  logic                         pixel_valid,
  output logic                         pixel_ready,
  input  logic [sgm_pkg::PIX_W-1:0]    pixel,
  output logic                         push,
  output sgm_pkg::entry_t              push_entry,
  input  logic                         full
);
  import sgm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  front_state_t       state, state_next;
  logic [PIX_W-1:0]   px;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [PIX_W-1:0]   rd_above, rd_two;
  window_t            win, win_next;
  logic [PIX_W-1:0]   line_above     [MAX_WIDTH];
  logic [PIX_W-1:0]   line_two_above [MAX_WIDTH];
  logic               accept, leave, last_col, last_row, col_ge1, row_ge1;
  logic [3:0]         mask;

  assign accept   = pixel_valid && pixel_ready;
  assign last_col = (CMP_W'(col) + CMP_W'(1)) == CMP_W'(eff_width);
  assign last_row = (CMP_W'(row) + CMP_W'(1)) == CMP_W'(eff_height);
  assign col_ge1  = col != '0;
  assign row_ge1  = row != '0;

  always_comb begin
    mask[EMIT_UP_LEFT]   = row_ge1 && col_ge1;
    mask[EMIT_UP_RIGHT]  = row_ge1 && col_ge1 && last_col;
    mask[EMIT_LOW_LEFT]  = last_row && col_ge1;
    mask[EMIT_LOW_RIGHT] = last_row && last_col;
  end

  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = {px, rd_above, rd_two};
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (pixel_valid) state_next = F_UPDATE;
      F_UPDATE: if (!(mask != '0 && full)) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_comb begin
    pixel_ready = 1'b0;
    leave       = 1'b0;
    case (state)
      F_IDLE:   pixel_ready = 1'b1;
      F_UPDATE: leave = !(mask != '0 && full);
      default:  ;
    endcase
  end

  assign push               = leave && mask != '0;
  assign push_entry.win     = win_next;
  assign push_entry.row     = COORD_W'(row);
  assign push_entry.col     = COORD_W'(col);
  assign push_entry.mask    = mask;
  assign push_entry.row_ge2 = row_ge1 && row != RW'(1);
  assign push_entry.col_ge2 = col_ge1 && col != CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      win   <= '0;
    end else begin
      state <= state_next;
      if (restart) begin
        col <= '0;
        row <= '0;
      end else if (leave) begin
        win <= win_next;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) px <= pixel;
  end

  always_ff @(posedge clk) begin
    if (accept) rd_above <= line_above[col];
    if (leave) line_above[col] <= px;
  end

  always_ff @(posedge clk) begin
    if (accept) rd_two <= line_two_above[col];
    if (leave) line_two_above[col] <= rd_above;
  end

endmodule

// ===== hdl/sgm_fifo.sv =====
// Short queue of classified pixel windows between front and back end.
// Depends on sgm_pkg.
module sgm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sgm_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output sgm_pkg::entry_t  pop_entry,
  output logic [sgm_pkg::QCNT_W-1:0] count
);
  import sgm_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign full      = count == QCNT_W'(QDEPTH);
  assign empty     = count == '0;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push && !full) - QCNT_W'(pop && !empty);
    end
  end

endmodule

// ===== hdl/sgm_back.sv =====
// Back end: walks the results of one queued window, computes the Sobel responses
// and an iterative integer square root, and drives the result word. Depends on sgm_pkg.
module sgm_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             empty,
  input  sgm_pkg::entry_t                  pop_entry,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sgm_pkg::COORD_W-1:0]      out_row,
  output logic [sgm_pkg::COORD_W-1:0]      out_col,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_x,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_y,
  output logic [sgm_pkg::GRAD_W-1:0]       grad_mag,
  output logic                             run_last,
  output logic                             frame_last
);
  import sgm_pkg::*;

  back_state_t          state, state_next;
  entry_t               ent;
  logic [3:0]           remain;
  logic [1:0]           kind;
  logic [SQ_W-1:0]      rem, res, bitv;
  logic [STEP_W-1:0]    step;
  logic [PIX_W-1:0]     p [3][3];
  logic signed [GRAD_W:0] gx_full, gy_full;
  logic [SQ_W:0]        trial;
  logic [3:0]           remain_after;
  logic                 done_root;

  function automatic logic [1:0] first_set(input logic [3:0] m);
    logic [1:0] k;
    k = EMIT_LOW_RIGHT;
    if (m[EMIT_LOW_LEFT]) k = EMIT_LOW_LEFT;
    if (m[EMIT_UP_RIGHT]) k = EMIT_UP_RIGHT;
    if (m[EMIT_UP_LEFT])  k = EMIT_UP_LEFT;
    return k;
  endfunction

  always_comb begin
    logic [1:0] cs [3];
    logic [1:0] ls [3];
    logic       left_side, upper;
    left_side = kind == EMIT_UP_LEFT || kind == EMIT_LOW_LEFT;
    upper     = kind == EMIT_UP_LEFT || kind == EMIT_UP_RIGHT;
    if (left_side) begin
      cs[0] = ent.col_ge2 ? 2'd0 : 2'd1;
      cs[1] = 2'd1;
      cs[2] = 2'd2;
    end else begin
      cs[0] = 2'd1;
      cs[1] = 2'd2;
      cs[2] = 2'd2;
    end
    if (upper) begin
      ls[0] = ent.row_ge2 ? 2'd0 : 2'd1;
      ls[1] = 2'd1;
      ls[2] = 2'd2;
    end else begin
      ls[0] = 2'd1;
      ls[1] = 2'd2;
      ls[2] = 2'd2;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] = ent.win[cs[j]][ls[i]];
      end
    end
  end

  always_comb begin
    gx_full = ($signed({4'b0, p[0][2]}) + $signed({3'b0, p[1][2], 1'b0})
              + $signed({4'b0, p[2][2]}))
            - ($signed({4'b0, p[0][0]}) + $signed({3'b0, p[1][0], 1'b0})
              + $signed({4'b0, p[2][0]}));
    gy_full = ($signed({4'b0, p[2][0]}) + $signed({3'b0, p[2][1], 1'b0})
              + $signed({4'b0, p[2][2]}))
            - ($signed({4'b0, p[0][0]}) + $signed({3'b0, p[0][1], 1'b0})
              + $signed({4'b0, p[0][2]}));
  end

  assign trial        = {1'b0, res} + {1'b0, bitv};
  assign done_root    = step == STEP_W'(ROOT_STEPS - 1);
  assign remain_after = remain & ~(4'b0001 << kind);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (!empty) state_next = B_GRAD;
      B_GRAD:   state_next = B_SQUARE;
      B_SQUARE: state_next = B_ROOT;
      B_ROOT:   if (done_root) state_next = B_OUT;
      B_OUT:    if (out_ready) state_next = (remain_after != '0) ? B_GRAD : B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state)
      B_IDLE:  pop = !empty;
      B_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign grad_mag = res[GRAD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        ent    <= pop_entry;
        remain <= pop_entry.mask;
        kind   <= first_set(pop_entry.mask);
      end
      B_GRAD: begin
        grad_x     <= gx_full[GRAD_W-1:0];
        grad_y     <= gy_full[GRAD_W-1:0];
        out_row    <= (kind == EMIT_UP_LEFT || kind == EMIT_UP_RIGHT)
                      ? ent.row - COORD_W'(1) : ent.row;
        out_col    <= (kind == EMIT_UP_LEFT || kind == EMIT_LOW_LEFT)
                      ? ent.col - COORD_W'(1) : ent.col;
        run_last   <= remain_after == '0;
        frame_last <= kind == EMIT_LOW_RIGHT;
      end
      B_SQUARE: begin
        rem  <= SQ_W'(SQ_W'(grad_x) * SQ_W'(grad_x) + SQ_W'(grad_y) * SQ_W'(grad_y));
        res  <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 1);
        step <= '0;
      end
      B_ROOT: begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[SQ_W-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        step <= step + STEP_W'(1);
      end
      B_OUT: begin
        if (out_ready) begin
          remain <= remain_after;
          kind   <= first_set(remain_after);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== dv/tb_sobel_gradient_magnitude.sv =====
// Self-checking testbench for sobel_gradient_magnitude: streams pixel frames of many sizes
// and compares each result word against a behavioral Sobel predictor held in a scoreboard.
// Depends on sgm_pkg and the RTL under hdl only.
module tb_sobel_gradient_magnitude;
  import sgm_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [GRAD_W-1:0]        mag;
    logic                     run_last;
    logic                     frame_last;
  } grad_word_t;

  class sobel_scoreboard;
    logic [REG_W-1:0] width_reg, height_reg;
    int unsigned row_cnt, col_cnt;
    logic [PIX_W-1:0] line1 [MAXW];
    logic [PIX_W-1:0] line2 [MAXW];
    logic [PIX_W-1:0] win [3][3];
    grad_word_t pending[$];
    int errors;

    function new();
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      row_cnt = 0;
      col_cnt = 0;
      errors = 0;
      for (int i = 0; i < MAXW; i++) begin
        line1[i] = '0;
        line2[i] = '0;
      end
      for (int s = 0; s < 3; s++)
        for (int l = 0; l < 3; l++) win[s][l] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
        if (idx == REG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        row_cnt = 0;
        col_cnt = 0;
      end
    endfunction

    function int unsigned clamp(logic [REG_W-1:0] v, int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned floor_root(int unsigned v);
      int unsigned m;
      m = 0;
      while ((m + 1) * (m + 1) <= v) m++;
      return m;
    endfunction

    function grad_word_t gradient(int unsigned r, int unsigned c, int lc, int mc, int rc,
                                  int tl, int ml, int bl, bit flast);
      int p [3][3];
      int cs [3];
      int ls [3];
      int gx, gy;
      grad_word_t w;
      cs[0] = lc; cs[1] = mc; cs[2] = rc;
      ls[0] = tl; ls[1] = ml; ls[2] = bl;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) p[i][j] = int'(win[cs[j]][ls[i]]);
      gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
      gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
      w.row = r[COORD_W-1:0];
      w.col = c[COORD_W-1:0];
      w.gx = gx[GRAD_W-1:0];
      w.gy = gy[GRAD_W-1:0];
      w.mag = GRAD_W'(floor_root(gx * gx + gy * gy));
      w.run_last = 1'b0;
      w.frame_last = flast;
      return w;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned w, h, r, c;
      bit last_col, last_row;
      int tl, lc, n;
      grad_word_t res [4];
      w = clamp(width_reg, MAXW);
      h = clamp(height_reg, MAXH);
      r = row_cnt;
      c = col_cnt;
      last_col = (c + 1 == w);
      last_row = (r + 1 == h);
      n = 0;
      for (int s = 0; s < 2; s++)
        for (int l = 0; l < 3; l++) win[s][l] = win[s+1][l];
      win[2][0] = line2[c];
      win[2][1] = line1[c];
      line2[c] = line1[c];
      line1[c] = px;
      win[2][2] = px;
      tl = (r >= 2) ? 0 : 1;
      lc = (c >= 2) ? 0 : 1;
      if (r >= 1 && c >= 1) begin
        res[n++] = gradient(r - 1, c - 1, lc, 1, 2, tl, 1, 2, 0);
        if (last_col) res[n++] = gradient(r - 1, c, 1, 2, 2, tl, 1, 2, 0);
      end
      if (last_row) begin
        if (c >= 1) res[n++] = gradient(r, c - 1, lc, 1, 2, 1, 2, 2, 0);
        if (last_col) res[n++] = gradient(r, c, 1, 2, 2, 1, 2, 2, 1);
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) pending.push_back(res[i]);
      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_word(grad_word_t got);
      grad_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word row %0d col %0d", $time, got.row, got.col);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.row !== exp.row || got.col !== exp.col || got.gx !== exp.gx ||
          got.gy !== exp.gy || got.mag !== exp.mag || got.run_last !== exp.run_last ||
          got.frame_last !== exp.frame_last) begin
        $display("%0t: mismatch expected row %0d col %0d gx %0d gy %0d mag %0d rl %0b fl %0b",
                 $time, exp.row, exp.col, exp.gx, exp.gy, exp.mag, exp.run_last,
                 exp.frame_last);
        $display("%0t:          actual row %0d col %0d gx %0d gy %0d mag %0d rl %0b fl %0b",
                 $time, got.row, got.col, got.gx, got.gy, got.mag, got.run_last,
                 got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  logic [PIX_W-1:0] pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COORD_W-1:0] out_row, out_col;
  logic signed [GRAD_W-1:0] grad_x, grad_y;
  logic [GRAD_W-1:0] grad_mag;
  logic run_last, frame_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;
  sobel_scoreboard sb = new();

  sobel_gradient_magnitude u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .grad_x(grad_x), .grad_y(grad_y),
    .grad_mag(grad_mag), .run_last(run_last), .frame_last(frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    grad_word_t got;
    if (!rst && out_valid && out_ready) begin
      got.row = out_row;
      got.col = out_col;
      got.gx = grad_x;
      got.gy = grad_y;
      got.mag = grad_mag;
      got.run_last = run_last;
      got.frame_last = frame_last;
      sb.check_word(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sobel_gradient_magnitude: done, errors");
      $finish;
    end
  end

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_size(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  task automatic send_random(int unsigned count, bit extremes);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(extremes ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom));
  endtask

  initial begin
    int unsigned sent, w, h, frames, total, mode;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes: first pixels of the first row
    send_random(4, 0);

    // directed: sizes below minimum act as 2, then 2x2 and 3x3 frames
    set_size(11'd0, 11'd1);
    send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'hFF);
    set_size(11'd2, 11'd2);
    send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'hFF);
    set_size(11'd3, 11'd3);
    for (int i = 0; i < 3; i++) begin
      send_pixel(8'h00); send_pixel(8'h00); send_pixel(8'hFF);
    end

    // sizes above the maximum act as the maximum
    set_size(11'd2047, 11'd2047);
    send_random(6, 0);

    sent = 0;
    mode = 0;
    while (sent < 240) begin
      set_idling(mode);
      mode++;
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      set_size(w[REG_W-1:0], h[REG_W-1:0]);
      frames = $urandom_range(1, 2);
      total = w * h * frames;
      // cut a frame short now and then, before a restart
      if ($urandom_range(4) == 0) total = $urandom_range(1, w * h - 1);
      for (int unsigned i = 0; i < total; i++) begin
        if (($urandom_range(3) == 0)) send_pixel($urandom_range(1) ? 8'hFF : 8'h00);
        else send_pixel(8'($urandom));
      end
      sent += total;
    end
    set_idling(0);
    drain();

    if (sb.errors == 0) begin
      $display("tb_sobel_gradient_magnitude: done, clean");
    end else begin
      $display("tb_sobel_gradient_magnitude: done, errors");
    end
    $finish;
  end

endmodule
